FILE: design/crwt_pkg.sv
`timescale 1ns / 1ps

package crwt_pkg;

    // Geometry
    localparam int SLOTS            = 64;
    localparam int REGS_PER_CHANNEL = 32;
    localparam int CH_W             = 6;
    localparam int REG_W            = 5;
    localparam int DATA_W           = 16;
    localparam int TBL_W            = 8;
    localparam int LVL_DEPTH        = 256;
    localparam int BASE_W           = 21;
    localparam int ADDR_W           = 23;
    localparam int HI_W             = ADDR_W - DATA_W;

    // Request codes of an input item
    typedef enum logic [1:0] {
        REQ_CMD      = 2'd0,
        REQ_LVL_LOAD = 2'd1,
        REQ_CH_LOAD  = 2'd2
    } t_req;

    // Configuration register indexes (byte address 4*index)
    typedef enum logic [1:0] {
        CFG_ABS_MODE    = 2'd0,
        CFG_SAMPLE_BASE = 2'd1,
        CFG_LVL_EN      = 2'd2,
        CFG_LVL_REG     = 2'd3
    } t_cfg_addr;

    typedef struct packed {
        logic              abs_mode;
        logic [BASE_W-1:0] sample_base;
        logic              lvl_en;
        logic [REG_W-1:0]  lvl_reg;
    } t_cfg;

    // Work for one command word, handed from the front stage to the result stage
    typedef struct packed {
        logic              has_first;
        logic              has_second;
        logic [REG_W-1:0]  reg_index;
        logic [DATA_W-1:0] data;
        logic              lookup;
        logic              end_first;
        logic [DATA_W-1:0] head_word;
    } t_item;

    typedef struct packed {
        logic             head_pending;
        logic [REG_W-1:0] word_pos;
    } t_front_status;

    typedef struct packed {
        logic valid;
        logic second;
    } t_out_status;

endpackage

FILE: design/channel_register_write_translator_unit.sv
`timescale 1ns / 1ps

// Channel     Direction  Handshake               Payload
// in          input      i_in_valid / o_in_stall  req_type, slot, start_reg, value, last,
//                                                 table_index, table_data
// out         output     o_out_valid / i_out_stall channel, register_index, data,
//                                                 end_of_command
// config      input      APB (psel/penable/...)   four registers at byte address 4*index
//
// An item is taken in every cycle unless a result stays in the result register. The last
// word of a command that started at register 0 also keeps it for the deferred head write
// when that word brings a write of its own. Table reads and the translated word register
// at the accepting edge, and the first write is offered in the following cycle.
// Reset is synchronous, active low; the tables are not cleared.
// A stalled result holds the result register and stalls the input in the same cycle.

module channel_register_write_translator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [5:0]  i_slot,
    input  logic [4:0]  i_start_reg,
    input  logic [15:0] i_value,
    input  logic        i_last,
    input  logic [7:0]  i_table_index,
    input  logic [7:0]  i_table_data,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_channel,
    output logic [4:0]  o_register_index,
    output logic [15:0] o_data,
    output logic        o_end_of_command,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    crwt_pkg::t_cfg                 r_cfg;
    crwt_pkg::t_item                w_item;
    crwt_pkg::t_front_status        w_front_st;
    crwt_pkg::t_out_status          w_out_st;
    crwt_pkg::t_cfg_addr            w_cfg_addr;
    logic                           w_cfg_write;
    logic                           w_in_accept;
    logic                           w_load;
    logic [crwt_pkg::CH_W-1:0]      w_ch_rd;
    logic [crwt_pkg::TBL_W-1:0]     w_lvl_rd;

    assign pready      = 1'b1;
    assign w_cfg_addr  = crwt_pkg::t_cfg_addr'(paddr[3:2]);
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.abs_mode    <= 1'b0;
            r_cfg.sample_base <= '0;
            r_cfg.lvl_en      <= 1'b0;
            r_cfg.lvl_reg     <= crwt_pkg::REG_W'(10);
        end else if (w_cfg_write) begin
            unique case (w_cfg_addr)
                crwt_pkg::CFG_ABS_MODE:    r_cfg.abs_mode    <= pwdata[0];
                crwt_pkg::CFG_SAMPLE_BASE: r_cfg.sample_base <= pwdata[crwt_pkg::BASE_W-1:0];
                crwt_pkg::CFG_LVL_EN:      r_cfg.lvl_en      <= pwdata[0];
                crwt_pkg::CFG_LVL_REG:     r_cfg.lvl_reg     <= pwdata[crwt_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (w_cfg_addr)
            crwt_pkg::CFG_ABS_MODE:    prdata = 32'(r_cfg.abs_mode);
            crwt_pkg::CFG_SAMPLE_BASE: prdata = 32'(r_cfg.sample_base);
            crwt_pkg::CFG_LVL_EN:      prdata = 32'(r_cfg.lvl_en);
            crwt_pkg::CFG_LVL_REG:     prdata = 32'(r_cfg.lvl_reg);
            default:                   prdata = '0;
        endcase
    end

    crwt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_req_type    (i_req_type),
        .i_slot        (i_slot),
        .i_start_reg   (i_start_reg),
        .i_value       (i_value),
        .i_last        (i_last),
        .i_table_index (i_table_index),
        .i_table_data  (i_table_data),
        .i_cfg         (r_cfg),
        .o_load        (w_load),
        .o_item        (w_item),
        .o_ch_rd       (w_ch_rd),
        .o_lvl_rd      (w_lvl_rd),
        .o_status      (w_front_st)
    );

    crwt_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_load),
        .i_item           (w_item),
        .i_ch_rd          (w_ch_rd),
        .i_lvl_rd         (w_lvl_rd),
        .i_out_stall      (i_out_stall),
        .o_busy           (o_in_stall),
        .o_out_valid      (o_out_valid),
        .o_channel        (o_channel),
        .o_register_index (o_register_index),
        .o_data           (o_data),
        .o_end_of_command (o_end_of_command),
        .o_status         (w_out_st)
    );

    // A result held by a stall leaves no room for a new item
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("item accepted while a stalled result holds the result stage");

    // The last word of a command clears the command progress
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept && (crwt_pkg::t_req'(i_req_type) == crwt_pkg::REQ_CMD) && i_last
        |=> (w_front_st.word_pos == '0) && !w_front_st.head_pending)
        else $error("command progress not cleared after the last word");

    // The deferred head write targets register 0 and ends its command
    a_head_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_st.valid && w_out_st.second |-> (o_register_index == '0) && o_end_of_command)
        else $error("deferred head write has wrong register or end mark");

endmodule

FILE: design/crwt_front.sv
`timescale 1ns / 1ps

module crwt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_req_type,
    input  logic [5:0]                    i_slot,
    input  logic [4:0]                    i_start_reg,
    input  logic [15:0]                   i_value,
    input  logic                          i_last,
    input  logic [7:0]                    i_table_index,
    input  logic [7:0]                    i_table_data,
    input  crwt_pkg::t_cfg                i_cfg,
    output logic                          o_load,
    output crwt_pkg::t_item               o_item,
    output logic [crwt_pkg::CH_W-1:0]     o_ch_rd,
    output logic [crwt_pkg::TBL_W-1:0]    o_lvl_rd,
    output crwt_pkg::t_front_status       o_status
);

    // Command progress
    logic [crwt_pkg::DATA_W-1:0] r_held;
    logic [crwt_pkg::DATA_W-1:0] n_held;
    logic                        r_head_pending;
    logic                        n_head_pending;
    logic [crwt_pkg::REG_W-1:0]  r_word_pos;
    logic [crwt_pkg::REG_W-1:0]  n_word_pos;

    // Tables
    logic [crwt_pkg::TBL_W-1:0]  lvl_mem [0:crwt_pkg::LVL_DEPTH-1];
    logic [crwt_pkg::CH_W-1:0]   ch_mem  [0:crwt_pkg::SLOTS-1];
    logic [crwt_pkg::TBL_W-1:0]  r_lvl_rd;
    logic [crwt_pkg::CH_W-1:0]   r_ch_rd;

    logic                        w_is_cmd;
    logic                        w_is_lvl_load;
    logic                        w_is_ch_load;
    logic                        w_hold;
    logic                        w_rebase;
    logic [crwt_pkg::REG_W:0]    w_reg_sum;
    logic [crwt_pkg::ADDR_W-1:0] w_abs;
    logic [crwt_pkg::DATA_W-1:0] w_data;
    logic [crwt_pkg::CH_W-1:0]   w_slot_idx;
    crwt_pkg::t_item             w_item;

    // Decode request
    assign w_is_cmd      = crwt_pkg::t_req'(i_req_type) == crwt_pkg::REQ_CMD;
    assign w_is_lvl_load = crwt_pkg::t_req'(i_req_type) == crwt_pkg::REQ_LVL_LOAD;
    assign w_is_ch_load  = crwt_pkg::t_req'(i_req_type) == crwt_pkg::REQ_CH_LOAD;

    // Clamp slot into the channel table
    assign w_slot_idx = ({1'b0, i_slot} >= 7'(crwt_pkg::SLOTS))
                      ? crwt_pkg::CH_W'(crwt_pkg::SLOTS - 1) : i_slot;

    // Translate one command word
    always_comb begin
        w_hold    = (r_word_pos == '0) && (i_start_reg == '0);
        w_reg_sum = {1'b0, i_start_reg} + {1'b0, r_word_pos};
        w_rebase  = r_head_pending && (r_word_pos == crwt_pkg::REG_W'(1)) && !i_cfg.abs_mode;
        w_abs     = crwt_pkg::ADDR_W'(i_cfg.sample_base)
                  + {r_held[crwt_pkg::HI_W-1:0], i_value};
        w_data    = w_rebase ? w_abs[crwt_pkg::DATA_W-1:0] : i_value;

        n_held = r_held;
        if (w_hold) begin
            n_held = i_value;
        end else if (w_rebase) begin
            n_held = {r_held[crwt_pkg::DATA_W-1:crwt_pkg::HI_W],
                      w_abs[crwt_pkg::ADDR_W-1:crwt_pkg::DATA_W]};
        end
        n_head_pending = r_head_pending || w_hold;
        n_word_pos     = r_word_pos + crwt_pkg::REG_W'(1);

        w_item.has_first  = !w_hold;
        w_item.has_second = i_last && n_head_pending;
        w_item.reg_index  = crwt_pkg::REG_W'(w_reg_sum % crwt_pkg::REGS_PER_CHANNEL);
        w_item.data       = w_data;
        w_item.lookup     = i_cfg.lvl_en && (w_item.reg_index == i_cfg.lvl_reg);
        w_item.end_first  = i_last && !r_head_pending;
        w_item.head_word  = n_held;
    end

    assign o_load = i_accept && w_is_cmd && (w_item.has_first || w_item.has_second);
    assign o_item = w_item;

    // Advance command progress; clear at the end of a command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held         <= '0;
            r_head_pending <= 1'b0;
            r_word_pos     <= '0;
        end else if (i_accept && w_is_cmd) begin
            r_held <= n_held;
            if (i_last) begin
                r_head_pending <= 1'b0;
                r_word_pos     <= '0;
            end else begin
                r_head_pending <= n_head_pending;
                r_word_pos     <= n_word_pos;
            end
        end
    end

    // Level table: load and registered lookup
    always_ff @(posedge i_clk) begin
        if (i_accept && w_is_lvl_load) begin
            lvl_mem[i_table_index] <= i_table_data;
        end
        if (o_load) begin
            r_lvl_rd <= lvl_mem[w_data[crwt_pkg::TBL_W-1:0]];
        end
    end

    // Channel table: load and registered lookup
    always_ff @(posedge i_clk) begin
        if (i_accept && w_is_ch_load
                && ({1'b0, i_table_index} < 9'(crwt_pkg::SLOTS))) begin
            ch_mem[i_table_index[crwt_pkg::CH_W-1:0]] <= i_table_data[crwt_pkg::CH_W-1:0];
        end
        if (o_load) begin
            r_ch_rd <= ch_mem[w_slot_idx];
        end
    end

    assign o_ch_rd  = r_ch_rd;
    assign o_lvl_rd = r_lvl_rd;

    assign o_status.head_pending = r_head_pending;
    assign o_status.word_pos     = r_word_pos;

endmodule

FILE: design/crwt_out.sv
`timescale 1ns / 1ps

module crwt_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  crwt_pkg::t_item               i_item,
    input  logic [crwt_pkg::CH_W-1:0]     i_ch_rd,
    input  logic [crwt_pkg::TBL_W-1:0]    i_lvl_rd,
    input  logic                          i_out_stall,
    output logic                          o_busy,
    output logic                          o_out_valid,
    output logic [5:0]                    o_channel,
    output logic [4:0]                    o_register_index,
    output logic [15:0]                   o_data,
    output logic                          o_end_of_command,
    output crwt_pkg::t_out_status         o_status
);

    crwt_pkg::t_item r_item;
    logic            r_valid;
    logic            r_second;
    logic            w_drain;
    logic            w_done;

    assign w_drain = r_valid && !i_out_stall;
    assign w_done  = w_drain && (r_second || !r_item.has_second);
    assign o_busy  = r_valid && !w_done;

    // Hold the item; step from its register write to the deferred head write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (i_load) begin
            r_valid  <= 1'b1;
            r_second <= !i_item.has_first;
        end else if (w_done) begin
            r_valid  <= 1'b0;
        end else if (w_drain) begin
            r_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    // Select the result shown on the port
    always_comb begin
        o_out_valid = r_valid;
        o_channel   = i_ch_rd;
        if (r_second) begin
            o_register_index = '0;
            o_data           = r_item.head_word;
            o_end_of_command = 1'b1;
        end else begin
            o_register_index = r_item.reg_index;
            o_data           = r_item.lookup
                             ? {r_item.data[crwt_pkg::DATA_W-1:crwt_pkg::TBL_W], i_lvl_rd}
                             : r_item.data;
            o_end_of_command = r_item.end_first;
        end
    end

    assign o_status.valid  = r_valid;
    assign o_status.second = r_second;

endmodule

FILE: tb/channel_register_write_translator_unit_tb.sv
`timescale 1ns / 1ps

module channel_register_write_translator_unit_tb;

    // Request code with no function; the block must drop it
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int LONG_HOLD  = 150;
    localparam int SETTLE     = 8;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  req;
        logic [5:0]  slot;
        logic [4:0]  start_reg;
        logic [15:0] value;
        logic        last;
        logic [7:0]  table_index;
        logic [7:0]  table_data;
    } t_word_item;

    typedef struct packed {
        logic [5:0]  channel;
        logic [4:0]  register_index;
        logic [15:0] data;
        logic        end_of_command;
    } t_reg_write;

    // Track the translator state and the register writes it owes
    class reg_write_scoreboard;
        logic                        abs_mode;
        logic [crwt_pkg::BASE_W-1:0] sample_base;
        logic                        lvl_en;
        logic [4:0]                  lvl_reg;
        logic [15:0]                 held_head;
        logic                        head_pending;
        logic [4:0]                  word_pos;
        logic [7:0]                  level_map [crwt_pkg::LVL_DEPTH];
        logic [5:0]                  slot_channels [crwt_pkg::SLOTS];
        t_reg_write                  expected_writes [$];
        int                          error_count;

        function new();
            abs_mode     = 1'b0;
            sample_base  = '0;
            lvl_en       = 1'b0;
            lvl_reg      = 5'd10;
            held_head    = '0;
            head_pending = 1'b0;
            word_pos     = '0;
            error_count  = 0;
            foreach (level_map[i]) level_map[i] = '0;
            foreach (slot_channels[i]) slot_channels[i] = '0;
        endfunction

        function void set_reg(crwt_pkg::t_cfg_addr idx, logic [31:0] val);
            case (idx)
                crwt_pkg::CFG_ABS_MODE:    abs_mode = val[0];
                crwt_pkg::CFG_SAMPLE_BASE: sample_base = val[crwt_pkg::BASE_W-1:0];
                crwt_pkg::CFG_LVL_EN:      lvl_en = val[0];
                crwt_pkg::CFG_LVL_REG:     lvl_reg = val[4:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted item and queue the writes it causes
        function void note_item(t_word_item it);
            logic [5:0]                  ch;
            logic [4:0]                  reg_idx;
            logic [15:0]                 data;
            logic [crwt_pkg::ADDR_W-1:0] addr;
            if (it.req == crwt_pkg::REQ_LVL_LOAD) begin
                level_map[it.table_index] = it.table_data;
                return;
            end
            if (it.req == crwt_pkg::REQ_CH_LOAD) begin
                if (it.table_index < crwt_pkg::SLOTS)
                    slot_channels[it.table_index[5:0]] = it.table_data[5:0];
                return;
            end
            if (it.req != crwt_pkg::REQ_CMD)
                return;

            ch = slot_channels[it.slot];
            if (word_pos == 5'd0 && it.start_reg == 5'd0) begin
                // Hold the head word until the command ends
                held_head    = it.value;
                head_pending = 1'b1;
            end else begin
                // 32 registers per channel: the sum wraps in 5 bits
                reg_idx = it.start_reg + word_pos;
                data    = it.value;
                if (head_pending && word_pos == 5'd1 && !abs_mode) begin
                    // Rebase the 23-bit sample address split over the two words
                    addr      = {held_head[6:0], it.value} + {2'b00, sample_base};
                    held_head = {held_head[15:7], addr[22:16]};
                    data      = addr[15:0];
                end
                if (lvl_en && reg_idx == lvl_reg)
                    data = {data[15:8], level_map[data[7:0]]};
                expected_writes.push_back(t_reg_write'{ch, reg_idx, data,
                                                       it.last && !head_pending});
            end

            if (it.last) begin
                if (head_pending)
                    expected_writes.push_back(t_reg_write'{ch, 5'd0, held_head, 1'b1});
                head_pending = 1'b0;
                word_pos     = '0;
            end else begin
                word_pos = word_pos + 5'd1;
            end
        endfunction

        function void check_write(t_reg_write got);
            t_reg_write want;
            if (expected_writes.size() == 0) begin
                $display("%0t: unexpected write: ch %0d reg %0d data %h end %0b", $time,
                         got.channel, got.register_index, got.data, got.end_of_command);
                error_count++;
                return;
            end
            want = expected_writes.pop_front();
            if (got !== want) begin
                $display("%0t: write mismatch: expected ch %0d reg %0d data %h end %0b,",
                         $time, want.channel, want.register_index, want.data,
                         want.end_of_command,
                         " got ch %0d reg %0d data %h end %0b",
                         got.channel, got.register_index, got.data, got.end_of_command);
                error_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [5:0]  i_slot;
    logic [4:0]  i_start_reg;
    logic [15:0] i_value;
    logic        i_last;
    logic [7:0]  i_table_index;
    logic [7:0]  i_table_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [5:0]  o_channel;
    logic [4:0]  o_register_index;
    logic [15:0] o_data;
    logic        o_end_of_command;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    reg_write_scoreboard sb;
    bit gaps_on       = 1'b1;
    int burst_left    = 0;
    bit long_hold_req = 1'b0;
    int idle_cycles   = 0;

    channel_register_write_translator_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_slot           (i_slot),
        .i_start_reg      (i_start_reg),
        .i_value          (i_value),
        .i_last           (i_last),
        .i_table_index    (i_table_index),
        .i_table_data     (i_table_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_channel        (o_channel),
        .o_register_index (o_register_index),
        .o_data           (o_data),
        .o_end_of_command (o_end_of_command),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Note each accepted item and check each accepted write
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_item(t_word_item'({i_req_type, i_slot, i_start_reg, i_value, i_last,
                                       i_table_index, i_table_data}));
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_write(t_reg_write'({o_channel, o_register_index, o_data,
                                         o_end_of_command}));
    end

    // Drop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("channel_register_write_translator_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // Stall the result side in stretches of changing pattern, or hold off on request
    initial begin : out_stall_pattern
        int stretch;
        int mode;
        int k;
        i_out_stall <= 1'b0;
        forever begin
            stretch = $urandom_range(10, 150);
            mode    = $urandom_range(0, 3);
            for (k = 0; k < stretch; k++) begin
                @(posedge i_clk);
                if (long_hold_req) begin
                    long_hold_req = 1'b0;
                    i_out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 9) < 7);
                    default: i_out_stall <= ((k % 5) < 2);
                endcase
            end
        end
    end

    function automatic t_word_item cmd_word(logic [5:0] slot, logic [4:0] start_reg,
                                            logic [15:0] value, logic last);
        t_word_item it;
        it.req         = crwt_pkg::REQ_CMD;
        it.slot        = slot;
        it.start_reg   = start_reg;
        it.value       = value;
        it.last        = last;
        it.table_index = 8'($urandom);
        it.table_data  = 8'($urandom);
        return it;
    endfunction

    function automatic t_word_item load_item(logic [1:0] req, logic [7:0] idx,
                                             logic [7:0] data);
        t_word_item it;
        it.req         = req;
        it.slot        = 6'($urandom);
        it.start_reg   = 5'($urandom);
        it.value       = 16'($urandom);
        it.last        = 1'($urandom);
        it.table_index = idx;
        it.table_data  = data;
        return it;
    endfunction

    // Level load anywhere, or channel load partly beyond the slot range
    function automatic t_word_item random_load();
        if ($urandom_range(0, 1) == 0)
            return load_item(crwt_pkg::REQ_LVL_LOAD, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 3) == 0)
            return load_item(crwt_pkg::REQ_CH_LOAD, 8'($urandom_range(crwt_pkg::SLOTS, 255)),
                             8'($urandom));
        return load_item(crwt_pkg::REQ_CH_LOAD, 8'($urandom_range(0, crwt_pkg::SLOTS - 1)),
                         8'($urandom));
    endfunction

    // Offer one item, with a random gap at the end of each burst
    task automatic send_item(input t_word_item it);
        if (gaps_on && burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_req_type    <= it.req;
        i_slot        <= it.slot;
        i_start_reg   <= it.start_reg;
        i_value       <= it.value;
        i_last        <= it.last;
        i_table_index <= it.table_index;
        i_table_data  <= it.table_data;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(input crwt_pkg::t_cfg_addr idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every owed write, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input logic absolute, input logic [crwt_pkg::BASE_W-1:0] base,
                             input logic lvl_on, input logic [4:0] lvl_reg);
        drain();
        write_reg(crwt_pkg::CFG_ABS_MODE, {31'd0, absolute});
        write_reg(crwt_pkg::CFG_SAMPLE_BASE, {{(32 - crwt_pkg::BASE_W){1'b0}}, base});
        write_reg(crwt_pkg::CFG_LVL_EN, {31'd0, lvl_on});
        write_reg(crwt_pkg::CFG_LVL_REG, {27'd0, lvl_reg});
    endtask

    // Mostly whole commands with random content, plus loads and dropped requests
    task automatic run_traffic(input int n_items, input bit with_gaps);
        int         done;
        int         len;
        int         w;
        int         roll;
        logic [5:0] slot;
        logic [4:0] start;
        logic [15:0] value;
        t_word_item it;
        gaps_on = with_gaps;
        done    = 0;
        while (done < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 7) begin
                it = random_load();
                send_item(it);
                done += (it.req == crwt_pkg::REQ_LVL_LOAD || it.table_index < crwt_pkg::SLOTS);
            end else if (roll < 9) begin
                send_item(load_item(REQ_UNUSED, 8'($urandom), 8'($urandom)));
            end else begin
                roll = $urandom_range(0, 99);
                len  = (roll < 80) ? $urandom_range(1, 6) :
                       (roll < 96) ? $urandom_range(7, 20) : $urandom_range(30, 40);
                slot = 6'($urandom);
                roll = $urandom_range(0, 9);
                start = (roll < 4) ? 5'd0 : (roll == 4) ? 5'd31 : 5'($urandom);
                for (w = 0; w < len; w++) begin
                    // Slip a load between words now and then
                    if ($urandom_range(0, 19) == 0) begin
                        it = random_load();
                        send_item(it);
                        done += (it.req == crwt_pkg::REQ_LVL_LOAD
                                 || it.table_index < crwt_pkg::SLOTS);
                    end
                    if ($urandom_range(0, 9) == 0)
                        slot = 6'($urandom);
                    if ($urandom_range(0, 14) == 0)
                        start = 5'($urandom);
                    case ($urandom_range(0, 9))
                        0:       value = 16'h0000;
                        1:       value = 16'hFFFF;
                        default: value = 16'($urandom);
                    endcase
                    send_item(cmd_word(slot, start, value, w == len - 1));
                    done++;
                end
            end
        end
    endtask

    initial begin : stimulus
        int i;
        int ph;
        sb = new();
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_req_type    <= crwt_pkg::REQ_CMD;
        i_slot        <= '0;
        i_start_reg   <= '0;
        i_value       <= '0;
        i_last        <= 1'b0;
        i_table_index <= '0;
        i_table_data  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(1'b0, '0, 1'b0, 5'd10);
        // Fill both tables so that no lookup reads an empty entry
        for (i = 0; i < crwt_pkg::SLOTS; i++)
            send_item(load_item(crwt_pkg::REQ_CH_LOAD, 8'(i), 8'($urandom)));
        for (i = 0; i < crwt_pkg::LVL_DEPTH; i++)
            send_item(load_item(crwt_pkg::REQ_LVL_LOAD, 8'(i), 8'($urandom)));

        // Directed: largest base, lookup on the rebased register
        configure(1'b0, '1, 1'b1, 5'd1);
        send_item(cmd_word(6'd0, 5'd0, 16'hFFFF, 1'b1));
        send_item(cmd_word(6'd63, 5'd0, 16'h00FF, 1'b0));
        send_item(cmd_word(6'd63, 5'd0, 16'hFFFF, 1'b0));
        send_item(cmd_word(6'd63, 5'd0, 16'h0000, 1'b1));
        send_item(cmd_word(6'd17, 5'd31, 16'h0001, 1'b0));
        send_item(cmd_word(6'd17, 5'd31, 16'h8000, 1'b1));
        send_item(load_item(REQ_UNUSED, 8'hFF, 8'hFF));
        send_item(load_item(crwt_pkg::REQ_CH_LOAD, 8'd255, 8'hFF));
        send_item(load_item(crwt_pkg::REQ_CH_LOAD, 8'd64, 8'h2A));
        send_item(load_item(crwt_pkg::REQ_CH_LOAD, 8'd63, 8'hFF));
        send_item(load_item(crwt_pkg::REQ_LVL_LOAD, 8'hFF, 8'h00));
        send_item(load_item(crwt_pkg::REQ_LVL_LOAD, 8'h00, 8'hFF));
        send_item(cmd_word(6'd63, 5'd0, 16'h7F00, 1'b0));
        send_item(load_item(crwt_pkg::REQ_LVL_LOAD, 8'h80, 8'h5A));
        send_item(cmd_word(6'd63, 5'd0, 16'h0080, 1'b0));
        send_item(cmd_word(6'd0, 5'd0, 16'h1234, 1'b1));
        send_item(cmd_word(6'd5, 5'd1, 16'h00FF, 1'b1));
        send_item(cmd_word(6'd42, 5'd30, 16'hFF00, 1'b0));
        send_item(cmd_word(6'd42, 5'd30, 16'h00FF, 1'b0));
        send_item(cmd_word(6'd42, 5'd30, 16'hA5A5, 1'b1));

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(1'b0, '0, 1'b0, 5'd10);
                1: configure(1'b1, '1, 1'b1, 5'd0);
                2: configure(1'b0, '1, 1'b1, 5'd31);
                3: configure(1'b0, crwt_pkg::BASE_W'($urandom), 1'b1, 5'd1);
                4: configure(1'b1, crwt_pkg::BASE_W'($urandom), 1'b0, 5'($urandom));
                5: configure(1'b0, crwt_pkg::BASE_W'($urandom), 1'b1, 5'($urandom));
                6: configure(1'b0, '0, 1'b1, 5'd2);
                default: configure(1'b0, crwt_pkg::BASE_W'($urandom), 1'b1, 5'd10);
            endcase
            // Hold off the result side while items keep coming
            if (ph == 2 || ph == 5) begin
                long_hold_req = 1'b1;
                run_traffic(50, 1'b0);
            end
            run_traffic(125, 1'b1);
        end

        drain();
        if (sb.error_count == 0 && sb.expected_writes.size() == 0)
            $display("channel_register_write_translator_unit_tb OK");
        else
            $display("channel_register_write_translator_unit_tb NOT OK");
        $finish;
    end

endmodule

FILE: channel_register_write_translator_unit.f
design/crwt_pkg.sv
design/crwt_front.sv
design/crwt_out.sv
design/channel_register_write_translator_unit.sv
tb/channel_register_write_translator_unit_tb.sv
